// ===== design/scds_pkg.sv =====
// Shared types and constants for the SPI clock divider search block.
// No dependencies; imported by scds_divider, spi_clock_divider_search_core and tb_top.
package scds_pkg;

  // Divider search range
  localparam int unsigned DivW       = 12;
  localparam int unsigned MaxDivider = 4095;
  localparam int unsigned DsrW       = DivW + 1;  // width of 2*divisor
  localparam int unsigned ClkW       = 32;

  localparam logic [DivW-1:0] MaxDivCode = DivW'(MaxDivider);

  // Mode byte decode
  localparam logic [7:0] ModeUnsupMask = 8'h54;  // bits 6, 4, 2
  localparam int unsigned ModeCsBit    = 5;

  // Configuration register indexes
  localparam logic CfgUnit0Clk = 1'b0;
  localparam logic CfgUnit4Clk = 1'b1;

  localparam logic [ClkW-1:0] ClkHzReset = 32'd48000000;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_PROTO   = 2'd1,
    STATUS_CHANNEL = 2'd2
  } status_e;

  // Control between sequencer and shared divider
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
  } div_stat_t;

endpackage

// ===== design/scds_divider.sv =====
// Shared restoring divider: 32-bit clock over a 13-bit divisor, one bit per cycle.
// Depends on scds_pkg.
module scds_divider
  import scds_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  div_ctrl_t       ctrl_i,
  input  logic [ClkW-1:0] dividend_i,
  input  logic [DsrW-1:0] divisor_i,
  output div_stat_t       stat_o,
  output logic [ClkW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(ClkW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [ClkW-1:0] quot_q, quot_d;
  logic [DsrW-1:0] rem_q, rem_d;
  logic [DsrW-1:0] dsr_q, dsr_d;

  logic [DsrW:0]   trial;
  logic            fits;

  // Shift in next dividend bit, subtract if divisor fits
  assign trial = {rem_q, quot_q[ClkW-1]};
  assign fits  = (trial >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? DsrW'(trial - {1'b0, dsr_q}) : DsrW'(trial);
      quot_d = {quot_q[ClkW-2:0], fits};
      cnt_d  = cnt_q + CntW'(1);
      if (cnt_q == CntW'(ClkW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign stat_o.done = done_q;
  assign quotient_o  = quot_q;

endmodule

// ===== design/spi_clock_divider_search_core.sv =====
// SPI clock divider search, top level: request decode, chip-select mask,
// search sequencer and output register. Depends on scds_pkg, scds_divider.
// Error requests pass from acceptance through S_FINISH to the output register,
//   which waits while the previous result is unaccepted. A valid channel runs each
//   trial divisor through S_START, the shared divider (S_WAIT) and S_EVAL, up to 4095 trials.
// One request at a time: in_ready is high only in S_IDLE.
// Reset: clocks return to 48 MHz, chip-select mask clears, no result pending.
module spi_clock_divider_search_core
  import scds_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [ClkW-1:0] cfg_data_i,
  // request
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [3:0]      channel_i,
  input  logic [31:0]     baud_rate_i,
  input  logic [7:0]      mode_i,
  // result
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      status_o,
  output logic [DivW-1:0] divider_o,
  output logic            idle_level_bit_o,
  output logic            data_phase_bit_o,
  output logic [15:0]     select_mask_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_EVAL,
    S_FINISH
  } state_e;

  state_e          state_q, state_d;

  // configuration
  logic [ClkW-1:0] unit0_clk_q, unit4_clk_q;

  // kept chip-select enables
  logic [15:0]     mask_q, mask_d;

  // search working registers
  logic [ClkW-1:0] clk_q, clk_d;
  logic [31:0]     baud_q, baud_d;
  logic [31:0]     best_q, best_d;
  logic [31:0]     dist_q, dist_d;
  logic [DivW-1:0] trial_q, trial_d;
  logic [DivW-1:0] chosen_q, chosen_d;
  status_e         stat_q, stat_d;
  logic            idle_q, idle_d;
  logic            phase_q, phase_d;

  // output register
  logic            ovalid_q, ovalid_d;
  logic [1:0]      ostat_q, ostat_d;
  logic [DivW-1:0] odiv_q, odiv_d;
  logic            oidle_q, oidle_d;
  logic            ophase_q, ophase_d;
  logic [15:0]     omask_q, omask_d;

  div_ctrl_t       div_ctrl;
  div_stat_t       div_stat;
  logic [ClkW-1:0] quotient;

  logic            accept;
  logic            proto_err;
  logic            chan_ok;
  logic [15:0]     chan_bit;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign proto_err  = |(mode_i & ModeUnsupMask);
  // channels 0, 4, 8, 12 are the only ones wired to a unit
  assign chan_ok    = (channel_i[1:0] == 2'b00);
  assign chan_bit   = 16'd1 << channel_i;

  assign div_ctrl.start = (state_q == S_START);

  scds_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (clk_q),
    .divisor_i  ({trial_q, 1'b0}),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d  = state_q;
    mask_d   = mask_q;
    clk_d    = clk_q;
    baud_d   = baud_q;
    best_d   = best_q;
    dist_d   = dist_q;
    trial_d  = trial_q;
    chosen_d = chosen_q;
    stat_d   = stat_q;
    idle_d   = idle_q;
    phase_d  = phase_q;
    ovalid_d = ovalid_q && !out_ready_i;
    ostat_d  = ostat_q;
    odiv_d   = odiv_q;
    oidle_d  = oidle_q;
    ophase_d = ophase_q;
    omask_d  = omask_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          chosen_d = '0;
          idle_d   = 1'b0;
          phase_d  = 1'b0;
          if (proto_err) begin
            stat_d  = STATUS_PROTO;
            state_d = S_FINISH;
          end else begin
            // mask is updated even when the channel turns out invalid
            mask_d = mode_i[ModeCsBit] ? (mask_q | chan_bit) : (mask_q & ~chan_bit);
            if (!chan_ok) begin
              stat_d  = STATUS_CHANNEL;
              state_d = S_FINISH;
            end else begin
              stat_d   = STATUS_OK;
              clk_d    = channel_i[2] ? unit4_clk_q : unit0_clk_q;
              best_d   = channel_i[2] ? unit4_clk_q : unit0_clk_q;
              baud_d   = baud_rate_i;
              trial_d  = DivW'(1);
              chosen_d = DivW'(1);
              idle_d   = !mode_i[1];
              phase_d  = mode_i[0];
              state_d  = S_START;
            end
          end
        end
      end
      S_START: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (div_stat.done) begin
          dist_d  = (baud_q >= quotient) ? (baud_q - quotient) : (quotient - baud_q);
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        // stop at the first trial that is not strictly nearer
        if (dist_q < best_q) begin
          best_d   = dist_q;
          chosen_d = trial_q;
          if (trial_q == MaxDivCode) begin
            state_d = S_FINISH;
          end else begin
            trial_d = trial_q + DivW'(1);
            state_d = S_START;
          end
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          ostat_d  = stat_q;
          odiv_d   = chosen_q;
          oidle_d  = idle_q;
          ophase_d = phase_q;
          omask_d  = mask_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      unit0_clk_q <= ClkHzReset;
      unit4_clk_q <= ClkHzReset;
      mask_q      <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      mask_q   <= mask_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgUnit0Clk: unit0_clk_q <= cfg_data_i;
          CfgUnit4Clk: unit4_clk_q <= cfg_data_i;
          default:     unit0_clk_q <= unit0_clk_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    clk_q    <= clk_d;
    baud_q   <= baud_d;
    best_q   <= best_d;
    dist_q   <= dist_d;
    trial_q  <= trial_d;
    chosen_q <= chosen_d;
    stat_q   <= stat_d;
    idle_q   <= idle_d;
    phase_q  <= phase_d;
    ostat_q  <= ostat_d;
    odiv_q   <= odiv_d;
    oidle_q  <= oidle_d;
    ophase_q <= ophase_d;
    omask_q  <= omask_d;
  end

  assign out_valid_o      = ovalid_q;
  assign status_o         = ostat_q;
  assign divider_o        = odiv_q;
  assign idle_level_bit_o = oidle_q;
  assign data_phase_bit_o = ophase_q;
  assign select_mask_o    = omask_q;

endmodule

// ===== sim/tb_top.sv =====
// Testbench for spi_clock_divider_search_core: directed and random requests,
// checked against an in-bench divider search model. Depends on scds_pkg and the RTL.
module tb_top;
  import scds_pkg::*;

  // Expected result of one request
  typedef struct {
    status_e         status;
    logic [DivW-1:0] divider;
    logic            idle_level;
    logic            data_phase;
    logic [15:0]     select_mask;
  } spi_setup_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  logic            cfg_index = CfgUnit0Clk;
  logic [ClkW-1:0] cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [3:0]      channel = '0;
  logic [31:0]     baud_rate = '0;
  logic [7:0]      mode = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [1:0]      status;
  logic [DivW-1:0] divider;
  logic            idle_level_bit;
  logic            data_phase_bit;
  logic [15:0]     select_mask;

  // Model state: unit clocks and the chip-select enable mask
  logic [31:0] unit0_hz = ClkHzReset;
  logic [31:0] unit4_hz = ClkHzReset;
  logic [15:0] cs_enables = '0;

  spi_setup_t settings_due[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Long receiver hold-off: main bumps hold_orders, the receiver counts it out
  int hold_orders = 0;
  int hold_taken = 0;
  int hold_left = 0;

  spi_clock_divider_search_core i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .channel_i        (channel),
    .baud_rate_i      (baud_rate),
    .mode_i           (mode),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .divider_o        (divider),
    .idle_level_bit_o (idle_level_bit),
    .data_phase_bit_o (data_phase_bit),
    .select_mask_o    (select_mask)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Walk divisors upward while clk/(2*d) keeps getting strictly closer to the
  // requested rate; the first non-improving step ends the walk.
  function automatic logic [DivW-1:0] nearest_divisor(input logic [31:0] clk_hz,
                                                      input logic [31:0] baud);
    longint unsigned closest;
    longint unsigned rate;
    longint unsigned gap;
    logic [DivW-1:0] pick;
    closest = 64'(clk_hz);
    pick = DivW'(1);
    for (int unsigned d = 1; d <= MaxDivider; d++) begin
      rate = longint'(clk_hz) / longint'(2 * d);
      gap = (baud >= rate) ? (baud - rate) : (rate - baud);
      if (gap < closest) begin
        closest = gap;
        pick = DivW'(d);
      end else begin
        break;
      end
    end
    return pick;
  endfunction

  // Expected result of one request; updates the mask as the block does
  function automatic spi_setup_t predict_setup(input logic [3:0] ch, input logic [31:0] baud,
                                               input logic [7:0] md);
    spi_setup_t r;
    r.status = STATUS_OK;
    r.divider = '0;
    r.idle_level = 1'b0;
    r.data_phase = 1'b0;
    if ((md & ModeUnsupMask) != '0) begin
      // protocol error wins over a bad channel and leaves the mask alone
      r.status = STATUS_PROTO;
    end else begin
      // mask moves even when the channel turns out invalid
      cs_enables[ch] = md[ModeCsBit];
      if (ch[1:0] == 2'b00) begin
        // 0/8 -> unit 0, 4/12 -> unit 4
        r.divider = nearest_divisor(ch[2] ? unit4_hz : unit0_hz, baud);
        r.idle_level = (md[1:0] <= 2'd1);
        r.data_phase = md[0];
      end else begin
        r.status = STATUS_CHANNEL;
      end
    end
    r.select_mask = cs_enables;
    return r;
  endfunction

  task automatic log_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", what);
  endtask

  // Offer one request and hold it until accepted. Valid stays high afterwards;
  // whoever comes next either re-drives it or lowers it.
  task automatic send_request(input logic [3:0] ch, input logic [31:0] baud,
                              input logic [7:0] md);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    channel <= ch;
    baud_rate <= baud;
    mode <= md;
    settings_due.push_back(predict_setup(ch, baud, md));
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every expected result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (settings_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Both clock registers, back to back; only called while idle
  task automatic set_clocks(input logic [31:0] clk0, input logic [31:0] clk4);
    cfg_we <= 1'b1;
    cfg_index <= CfgUnit0Clk;
    cfg_data <= clk0;
    @(posedge clk);
    cfg_index <= CfgUnit4Clk;
    cfg_data <= clk4;
    @(posedge clk);
    cfg_we <= 1'b0;
    unit0_hz = clk0;
    unit4_hz = clk4;
    @(posedge clk);
  endtask

  task automatic send_error_request();
    logic [7:0] bad;
    if ($urandom_range(1)) begin
      bad = 8'h04 << (2 * $urandom_range(2));
      send_request(4'($urandom), $urandom, 8'($urandom) | bad);
    end else begin
      send_request({2'($urandom_range(3)), 2'($urandom_range(3, 1))}, $urandom,
                   8'($urandom) & ~ModeUnsupMask);
    end
  endtask

  // Mostly searchable requests: baud near clk/(2*d) for a small d keeps the
  // divider walk short; a few fully random rates, and error requests (40%) mixed in.
  task automatic send_random_request();
    logic [3:0]  ch;
    logic [31:0] clk_hz;
    logic [31:0] rate;
    logic [31:0] baud;
    int unsigned d;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick >= 60) begin
      send_error_request();
    end else begin
      ch = 4'($urandom_range(3)) << 2;
      clk_hz = ch[2] ? unit4_hz : unit0_hz;
      pick = $urandom_range(99);
      if (pick < 80) d = $urandom_range(30, 1);
      else d = $urandom_range(300, 31);
      rate = clk_hz / (32'(d) * 2);
      if (pick >= 95) baud = $urandom;
      else baud = rate - rate / 8 + $urandom_range(rate / 4);
      send_request(ch, baud, 8'($urandom) & ~ModeUnsupMask);
    end
  endtask

  // Result side: random ready, long hold-off on request, in-order compare
  always @(posedge clk) begin : result_monitor
    spi_setup_t exp;
    if (rst_n && out_valid && out_ready) begin
      if (settings_due.size() == 0) begin
        log_failure($sformatf("unexpected result st=%0d div=%0d idle=%0b ph=%0b mask=%h",
                              status, divider, idle_level_bit, data_phase_bit, select_mask));
      end else begin
        exp = settings_due.pop_front();
        if (status !== exp.status || divider !== exp.divider
            || idle_level_bit !== exp.idle_level || data_phase_bit !== exp.data_phase
            || select_mask !== exp.select_mask) begin
          log_failure($sformatf(
            "exp st=%0d div=%0d idle=%0b ph=%0b mask=%h got st=%0d div=%0d idle=%0b ph=%0b mask=%h",
            exp.status, exp.divider, exp.idle_level, exp.data_phase, exp.select_mask,
            status, divider, idle_level_bit, data_phase_bit, select_mask));
        end
      end
    end
    if (hold_orders != hold_taken) begin
      hold_taken = hold_orders;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Reset clocks (48 MHz on both units): field extremes, every mode decode,
  // both error kinds and their overlap, mask set/clear on valid and bad channels.
  task automatic test_directed_cases();
    send_request(4'd0, 32'd0, 8'h00);             // longest walk, ends at MaxDivider
    send_request(4'd4, 32'hFFFF_FFFF, 8'h03);     // no gain at divisor 1
    send_request(4'd8, 32'd1_000_000, 8'h21);
    send_request(4'd12, 32'd4_800_000, 8'h8A);    // exact rate, spare mode bits set
    send_request(4'd1, 32'h1234_5678, 8'h20);     // bad channel still sets its mask bit
    send_request(4'd15, 32'd24_000_000, 8'h20);
    send_request(4'd15, 32'd0, 8'h00);            // and clears it
    send_request(4'd3, 32'd100, 8'h54);           // both errors: protocol reported
    send_request(4'd0, 32'd5_000, 8'h04);
    send_request(4'd4, 32'd5_000, 8'h10);
    send_request(4'd8, 32'd5_000, 8'h40);
    send_request(4'd12, 32'hFFFF_FFFF, 8'hFF);
    send_request(4'd0, 32'd3_000_000, 8'h01);
    send_request(4'd4, 32'd2_000_000, 8'h22);
    send_request(4'd12, 32'd24_000_001, 8'hA3);
    send_request(4'd8, 32'd750_000, 8'h00);
    send_request(4'd0, 32'd48_000_000, 8'h20);
    send_request(4'd7, 32'hA5A5_A5A5, 8'h8B);
    send_request(4'd11, 32'h5A5A_5A5A, 8'hAB);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int count, input logic [31:0] clk0,
                                     input logic [31:0] clk4, input int send_pct,
                                     input int recv_pct);
    wait_idle();
    set_clocks(clk0, clk4);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_random_request();
    wait_idle();
  endtask

  // Receiver holds off while requests keep coming, so the block backs up
  // and drops in_ready; then the sender waits for everything to drain.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_orders++;
    @(posedge clk);
    repeat (8) send_error_request();
    send_request(4'd4, unit4_hz / 10, 8'h21);
    wait_idle();
  endtask

  initial begin : main_sequence
    logic [31:0] clk0;
    logic [31:0] clk4;
    int waited;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 12;
    recv_idle_pct = 53;
    test_directed_cases();
    test_random_traffic(25, 32'd48_000_000, 32'hFFFF_FFFF, 12, 53);
    test_random_traffic(25, 32'd1, 32'd100_000_000, 53, 12);
    do clk0 = $urandom; while (clk0 == '0);
    do clk4 = $urandom; while (clk4 == '0);
    test_random_traffic(20, clk0, clk4, 0, 0);
    test_output_backpressure();

    in_valid <= 1'b0;
    waited = 0;
    while (settings_due.size() != 0 && waited < 300000) begin
      @(posedge clk);
      waited++;
    end
    if (settings_due.size() != 0) log_failure("results still outstanding at end of run");
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: a few full-length divider walks plus ~100 short ones fit
  // well inside this
  initial begin : watchdog
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
